// File: hdl/idq_pkg.sv
package idq_pkg;

  // Fixed field widths of the request and result beats
  localparam int CMD_W   = 2;
  localparam int POS_W   = 9;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 9;

  // Fan-in of one stage of the read-out OR tree
  localparam int TREE_RADIX = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WAIT = 1'b1
  } fsm_t;

  // Per-cycle command broadcast along the row of cells
  typedef struct packed {
    logic ins;  // open a gap at idx, shift the tail up
    logic del;  // close the gap at idx, shift the tail down
    logic rd;   // cell at idx drives its word into the tree
  } cell_ctl_t;

  // Number of registered stages the OR tree needs for n leaves
  function automatic int tree_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = TREE_RADIX;
    while (span < n) begin
      span = span * TREE_RADIX;
      lv   = lv + 1;
    end
    return lv;
  endfunction

endpackage

// File: hdl/idq_cell.sv
module idq_cell #(
  parameter int W        = 32,
  parameter int IW       = 8,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  idq_pkg::cell_ctl_t ctl_i,
  input  logic [IW-1:0]     idx_i,
  input  logic [W-1:0]      word_i,
  input  logic [W-1:0]      prev_i,
  input  logic [W-1:0]      next_i,
  output logic [W-1:0]      data_o,
  output logic [W-1:0]      leaf_o
);
  import idq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;
  logic         at_idx;
  logic         above_idx;

  assign at_idx    = (idx_i == MY_IDX);
  assign above_idx = (MY_IDX > idx_i);

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins) begin
      if (at_idx) begin
        data_nxt = word_i;
      end else if (above_idx) begin
        data_nxt = prev_i;
      end
    end else if (ctl_i.del) begin
      if (at_idx || above_idx) begin
        data_nxt = next_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign leaf_o = (ctl_i.rd && at_idx) ? data_r : '0;

endmodule

// File: hdl/idq_or_tree.sv
module idq_or_tree #(
  parameter int N = 256,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [W-1:0] leaf_i [N],
  output logic         vld_o,
  output logic [W-1:0] data_o
);
  import idq_pkg::*;

  localparam int L = tree_levels(N);

  function automatic int pow_r(input int e);
    int p;
    p = 1;
    for (int k = 0; k < e; k++) begin
      p = p * TREE_RADIX;
    end
    return p;
  endfunction

  // first node of stage s in the flat node array
  function automatic int node_off(input int s);
    int o;
    o = 0;
    for (int k = 0; k < s; k++) begin
      o = o + pow_r(L - 1 - k);
    end
    return o;
  endfunction

  localparam int NP  = pow_r(L);
  localparam int TOT = node_off(L);

  logic [W-1:0] leaf_pad [NP];
  logic [W-1:0] node_r   [TOT];
  logic         vld_r    [L];

  for (genvar i = 0; i < NP; i++) begin : g_pad
    if (i < N) begin : g_real
      assign leaf_pad[i] = leaf_i[i];
    end else begin : g_zero
      assign leaf_pad[i] = '0;
    end
  end

  for (genvar s = 0; s < L; s++) begin : g_stage
    for (genvar j = 0; j < pow_r(L - 1 - s); j++) begin : g_node
      if (s == 0) begin : g_first
        always_ff @(posedge clk) begin
          logic [W-1:0] acc;
          acc = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            acc = acc | leaf_pad[j*TREE_RADIX + k];
          end
          node_r[node_off(s) + j] <= acc;
        end
      end else begin : g_upper
        always_ff @(posedge clk) begin
          logic [W-1:0] acc;
          acc = '0;
          for (int k = 0; k < TREE_RADIX; k++) begin
            acc = acc | node_r[node_off(s - 1) + j*TREE_RADIX + k];
          end
          node_r[node_off(s) + j] <= acc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < L; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= vld_i;
      for (int s = 1; s < L; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign vld_o  = vld_r[L-1];
  assign data_o = node_r[TOT-1];

endmodule

// File: hdl/indexed_deque_store.sv
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+-----------------------------------------
// in_      | into      | in_valid / in_stall  | cmd, from_back, position, data_in
// out_     | out of    | out_valid / out_stall| read_data, status, element_count
//
// One request beat is taken at a time. Cells shift on the accepting edge, so
// inserts and erases finish in that cycle; the read word then climbs a
// radix-16 registered OR tree and then the result register, which raises
// out_valid. The next request can be taken as soon as out_valid rises,
// while out_stall stays low. rst_n is synchronous; it clears the count and
// the control path, the stored words stay as they are. in_stall is high while
// a request is in the tree, or while a result is held under out_stall; the
// result register keeps its beat until it is taken.
module indexed_deque_store #(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [idq_pkg::CMD_W-1:0]   in_cmd,
  input  logic                        in_from_back,
  input  logic [idq_pkg::POS_W-1:0]   in_position,
  input  logic [idq_pkg::WORD_W-1:0]  in_data_in,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [idq_pkg::WORD_W-1:0]  out_read_data,
  output logic [idq_pkg::STAT_W-1:0]  out_status,
  output logic [idq_pkg::COUNT_W-1:0] out_element_count
);
  import idq_pkg::*;

  // stored word width: words are cut to the 32-bit field and to DATA_WIDTH
  localparam int SW = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // arithmetic width covering both the count and the 9-bit position
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  fsm_t              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           res_stat_r, res_stat_nxt;
  logic              out_valid_r;
  logic [SW-1:0]     out_data_r;
  status_t           out_stat_r;
  logic [CW-1:0]     out_count_r;

  logic              accept;
  cmd_t              cmd;
  logic [XW-1:0]     pos_x, n_x, idx_x;
  logic [IW-1:0]     idx;
  cell_ctl_t         ctl;
  logic [SW-1:0]     word;

  logic [SW-1:0]     cell_q [CAPACITY];
  logic [SW-1:0]     leaf   [CAPACITY];
  logic              tree_vld;
  logic [SW-1:0]     tree_data;
  logic [XW-1:0]     cnt_x;

  assign in_stall = (state_r == FSM_WAIT) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_cmd);
  assign pos_x    = XW'(in_position);
  assign n_x      = XW'(count_r);
  assign word     = in_data_in[SW-1:0];
  assign idx      = idx_x[IW-1:0];

  // Request decode: bound checks, physical index, cell commands
  always_comb begin
    ctl          = '0;
    idx_x        = pos_x;
    count_nxt    = count_r;
    res_stat_nxt = ST_DONE;
    unique case (cmd)
      CMD_CLEAR: begin
        count_nxt = '0;
      end
      CMD_INSERT: begin
        idx_x = in_from_back ? (n_x - pos_x) : pos_x;
        if (pos_x > n_x) begin
          res_stat_nxt = ST_OOB;
        end else if (count_r == CAP_C) begin
          res_stat_nxt = ST_FULL;
        end else begin
          ctl.ins   = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_READ, CMD_ERASE: begin
        idx_x = in_from_back ? (n_x - XW'(1) - pos_x) : pos_x;
        if (pos_x >= n_x) begin
          res_stat_nxt = ST_OOB;
        end else begin
          ctl.rd = 1'b1;
          if (cmd == CMD_ERASE) begin
            ctl.del   = 1'b1;
            count_nxt = count_r - CW'(1);
          end
        end
      end
      default: begin
        res_stat_nxt = ST_DONE;
      end
    endcase
    // nothing moves unless the beat is actually taken
    if (!accept) begin
      ctl = '0;
    end
  end

  // Row of cells, front of the store in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SW-1:0] prev_w;
    logic [SW-1:0] next_w;
    if (i == 0) begin : g_lo
      assign prev_w = '0;
    end else begin : g_lo_n
      assign prev_w = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign next_w = '0;
    end else begin : g_hi_n
      assign next_w = cell_q[i+1];
    end
    idq_cell #(
      .W        (SW),
      .IW       (IW),
      .CELL_IDX (i)
    ) u_cell (
      .clk    (clk),
      .ctl_i  (ctl),
      .idx_i  (idx),
      .word_i (word),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_q[i]),
      .leaf_o (leaf[i])
    );
  end

  // Read-out: the addressed cell's word (or zero) is OR-ed down to one word
  idq_or_tree #(
    .N (CAPACITY),
    .W (SW)
  ) u_tree (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (accept),
    .leaf_i (leaf),
    .vld_o  (tree_vld),
    .data_o (tree_data)
  );

  // Control FSM: one request in flight
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt = FSM_WAIT;
        end
      end
      FSM_WAIT: begin
        if (tree_vld) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
      // a fresh result only lands once the previous beat has gone
      if (tree_vld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_stat_r <= res_stat_nxt;
    end
    if (tree_vld) begin
      out_data_r  <= tree_data;
      out_stat_r  <= res_stat_r;
      out_count_r <= count_r;
    end
  end

  assign cnt_x             = XW'(out_count_r);
  assign out_valid         = out_valid_r;
  assign out_read_data     = WORD_W'(out_data_r);
  assign out_status        = out_stat_r;
  assign out_element_count = cnt_x[COUNT_W-1:0];

endmodule

// File: hdl/idq_checker.sv
module idq_checker #(
  parameter int CAPACITY = 256
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [idq_pkg::WORD_W-1:0]  out_read_data,
  input logic [idq_pkg::STAT_W-1:0]  out_status,
  input logic [idq_pkg::COUNT_W-1:0] out_element_count
);
  import idq_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

  // a failed request never returns a word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_read_data == '0))
    else $error("failed request returned data");

  // full is only reported when the store really is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_element_count == CAP_C))
    else $error("full status with spare room");

  // no status code outside done, out of bound and full
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || (out_status == ST_OOB)
                  || (out_status == ST_FULL))
    else $error("reserved status code");

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
                               && $stable(out_status) && $stable(out_element_count))
    else $error("result beat changed under stall");

endmodule

bind indexed_deque_store idq_checker #(.CAPACITY(CAPACITY)) u_idq_checker (.*);

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import idq_pkg::*;

  // Store depth as built here; positions run 0..DEPTH, so bit 8 of the
  // position is only ever set by DEPTH itself.
  localparam int DEPTH          = 256;
  localparam int HOLD_CYCLES    = 300;   // long result hold-off
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

  // One result beat as the store should present it
  typedef struct {
    logic [WORD_W-1:0]  word;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } deque_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = CMD_READ;
  logic                 in_from_back = 1'b0;
  logic [POS_W-1:0]     in_position = '0;
  logic [WORD_W-1:0]    in_data_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    out_read_data;
  logic [STAT_W-1:0]    out_status;
  logic [COUNT_W-1:0]   out_element_count;

  // Shadow of the stored words, front at index 0, and the results owed
  logic [WORD_W-1:0]    shadow_words[$];
  deque_result_t        awaited_results[$];

  int unsigned          failures = 0;
  int                   idle_pct = 35;   // chance per cycle that a side idles
  int                   holds_asked = 0;
  int                   holds_served = 0;
  int                   hold_left = 0;
  int                   quiet_cycles = 0;

  always #6 clk = ~clk;

  indexed_deque_store #(
    .CAPACITY   (DEPTH),
    .DATA_WIDTH (WORD_W)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_from_back      (in_from_back),
    .in_position       (in_position),
    .in_data_in        (in_data_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_status        (out_status),
    .out_element_count (out_element_count)
  );

  // ---------------------------------------------------------------------
  // Shadow deque: apply one accepted request and queue the result it owes.
  // Bound check before the full check; failed requests change nothing.
  // ---------------------------------------------------------------------
  task automatic apply_to_shadow(input cmd_t op, input logic back,
                                 input logic [POS_W-1:0] pos,
                                 input logic [WORD_W-1:0] word);
    deque_result_t r;
    int            n;
    int            idx;
    n        = shadow_words.size();
    r.word   = '0;
    r.status = ST_DONE;
    case (op)
      CMD_CLEAR: begin
        shadow_words.delete();
      end
      CMD_INSERT: begin
        if (pos > n) begin
          r.status = ST_OOB;
        end else if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // from the back, the new word lands before index count - position
          idx = back ? n - pos : pos;
          shadow_words.insert(idx, word);
        end
      end
      default: begin
        // read and erase share the bound and the index mapping
        if (pos >= n) begin
          r.status = ST_OOB;
        end else begin
          idx    = back ? n - 1 - pos : pos;
          r.word = shadow_words[idx];
          if (op == CMD_ERASE) shadow_words.delete(idx);
        end
      end
    endcase
    r.count = COUNT_W'(shadow_words.size());
    awaited_results.insert(awaited_results.size(), r);
  endtask

  // ---------------------------------------------------------------------
  // Request side: random idle cycles, then hold the beat until taken.
  // in_valid stays high into the next beat when there is no gap, so it
  // only ever gets one assignment per edge.
  // ---------------------------------------------------------------------
  task automatic send_request(input cmd_t op, input logic back,
                              input logic [POS_W-1:0] pos,
                              input logic [WORD_W-1:0] word);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= op;
    in_from_back <= back;
    in_position  <= pos;
    in_data_in   <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_to_shadow(op, back, pos, word);
  endtask

  // Weighted random request. Positions are mostly in range for the current
  // count; wild_pct of them are drawn over 0..DEPTH instead.
  task automatic random_request(input int ins_pct, input int del_pct,
                                input int wild_pct, input bit may_clear);
    int                 roll;
    int                 n;
    cmd_t               op;
    logic [POS_W-1:0]   pos;
    n    = shadow_words.size();
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) op = CMD_INSERT;
    else if (roll < ins_pct + del_pct) op = CMD_ERASE;
    else if (roll < 99 || !may_clear) op = CMD_READ;
    else op = CMD_CLEAR;
    if ($urandom_range(0, 99) < wild_pct) pos = POS_W'($urandom_range(0, DEPTH));
    else if (op == CMD_INSERT) pos = POS_W'($urandom_range(0, n));
    else pos = POS_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
    send_request(op, 1'($urandom_range(0, 1)), pos, $urandom());
  endtask

  // ---------------------------------------------------------------------
  // Result side. Random stall, or a long hold-off when a test asks for one;
  // the hold-off is counted here so the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // Every taken result beat against the oldest one owed, field by field
  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        failures++;
        $display("%0t: result beat with none owed: data %h status %0d count %0d",
                 $time, out_read_data, out_status, out_element_count);
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        if (out_read_data !== want.word) begin
          failures++;
          $display("%0t: read_data expected %h actual %h",
                   $time, want.word, out_read_data);
        end
        if (out_status !== want.status) begin
          failures++;
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_status);
        end
        if (out_element_count !== want.count) begin
          failures++;
          $display("%0t: element_count expected %0d actual %0d",
                   $time, want.count, out_element_count);
        end
      end
    end
  end

  // Watchdog: any beat on either side restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("indexed_deque_store regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty store, both ends, extreme words and positions, clear
  task automatic test_corner_requests();
    send_request(CMD_READ,   1'b0, 9'd0,   32'h0000_0000); // read on empty
    send_request(CMD_ERASE,  1'b1, 9'd0,   32'hFFFF_FFFF); // erase on empty
    send_request(CMD_INSERT, 1'b0, 9'd1,   32'h1234_5678); // insert past count
    send_request(CMD_INSERT, 1'b1, 9'd0,   32'h0000_0000); // first word, from back
    send_request(CMD_INSERT, 1'b0, 9'd1,   32'hFFFF_FFFF); // append at count
    send_request(CMD_INSERT, 1'b1, 9'd0,   32'hA5A5_A5A5); // push back
    send_request(CMD_INSERT, 1'b0, 9'd0,   32'h5A5A_5A5A); // push front
    send_request(CMD_READ,   1'b1, 9'd0,   32'hFFFF_FFFF); // back word
    send_request(CMD_READ,   1'b0, 9'd3,   32'h0000_0000); // last in range
    send_request(CMD_READ,   1'b0, 9'd4,   32'h0000_0000); // one beyond count
    send_request(CMD_READ,   1'b1, 9'd4,   32'h0000_0000); // beyond, from back
    send_request(CMD_INSERT, 1'b0, 9'd256, 32'hDEAD_BEEF); // top position
    send_request(CMD_ERASE,  1'b0, 9'd1,   32'h0000_0000); // erase mid
    send_request(CMD_ERASE,  1'b1, 9'd0,   32'h0000_0000); // pop back
    send_request(CMD_READ,   1'b1, 9'd256, 32'h0000_0000);
    send_request(CMD_CLEAR,  1'b1, 9'd256, 32'hFFFF_FFFF); // fields ignored
    send_request(CMD_READ,   1'b0, 9'd0,   32'h0000_0000);
    send_request(CMD_INSERT, 1'b1, 9'd1,   32'h0000_0001); // past count, from back
    send_request(CMD_INSERT, 1'b1, 9'd0,   $urandom());
    send_request(CMD_ERASE,  1'b0, 9'd0,   32'h0000_0000); // pop front to empty
    send_request(CMD_ERASE,  1'b0, 9'd0,   32'h0000_0000);
    send_request(CMD_CLEAR,  1'b0, 9'd0,   32'h0000_0000); // clear when empty
  endtask

  // Grow to capacity, hit the full status, then drain to empty
  task automatic test_fill_to_capacity();
    send_request(CMD_CLEAR, 1'b0, 9'd0, $urandom());
    while (shadow_words.size() < DEPTH) random_request(85, 0, 0, 1'b0);
    send_request(CMD_INSERT, 1'b0, 9'd256, $urandom());              // full
    send_request(CMD_INSERT, 1'b1, 9'd0,   $urandom());              // full
    send_request(CMD_INSERT, 1'($urandom_range(0, 1)),
                 POS_W'($urandom_range(0, DEPTH)), $urandom());
    send_request(CMD_READ,   1'b0, 9'd255, '0);
    send_request(CMD_READ,   1'b1, 9'd255, '0);                      // front word
    send_request(CMD_READ,   1'b0, 9'd256, '0);                      // beyond, full
    send_request(CMD_ERASE,  1'b1, 9'd255, '0);                      // pop front
    send_request(CMD_INSERT, 1'b1, 9'd255, $urandom());              // refill at front
    send_request(CMD_ERASE,  1'b0, 9'd255, '0);                      // pop back
    while (shadow_words.size() > 0) random_request(0, 85, 0, 1'b0);
    send_request(CMD_ERASE,  1'b1, 9'd0, '0);
  endtask

  // Runs of growth, shrinkage, churn and out-of-range noise
  task automatic test_random_traffic(input int runs);
    int mode;
    int len;
    repeat (runs) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(30, 70);
      repeat (len) begin
        case (mode)
          0:       random_request(65, 15, 5,   1'b1);
          1:       random_request(15, 65, 5,   1'b1);
          2:       random_request(33, 33, 10,  1'b1);
          default: random_request(25, 25, 100, 1'b1);
        endcase
      end
    end
  endtask

  // Results held off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    holds_asked++;
    repeat (40) random_request(50, 25, 5, 1'b0);
  endtask

  // No idling on either side: beats as close as the block allows
  task automatic test_back_to_back();
    idle_pct = 0;
    repeat (120) random_request(40, 35, 10, 1'b1);
    idle_pct = 35;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_requests();
    test_fill_to_capacity();
    test_random_traffic(10);
    test_output_hold_off();
    test_back_to_back();
    test_random_traffic(10);

    // drop valid, then let every owed result come out
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("indexed_deque_store regression: pass");
    else
      $display("indexed_deque_store regression: fail");
    $finish;
  end

endmodule

// File: sim.f
hdl/idq_pkg.sv
hdl/idq_cell.sv
hdl/idq_or_tree.sv
hdl/indexed_deque_store.sv
hdl/idq_checker.sv
sim/testbench.sv
